>>> hdl/pearson_string_hash_assert.svh
// assertion macros of the pearson string hash checker
`ifndef PEARSON_STRING_HASH_ASSERT_SVH
`define PEARSON_STRING_HASH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/pshash_pkg.sv
// package: constants, types, permutation table and packing helpers of the string hash
`default_nettype none

package pshash_pkg;

    localparam int MAX_LANES = 4;
    localparam int LANE_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 5;
    localparam int HASH_W    = 30;
    localparam int PACK_W    = 4 * LANE_W;
    localparam int PERM_D    = 256;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

    // size limits for one, two and three lanes
    localparam logic [CFG_W-1:0] LG_ONE_LANE   = 5'd8;
    localparam logic [CFG_W-1:0] LG_TWO_LANES  = 5'd16;
    localparam logic [CFG_W-1:0] LG_THREE_LANES = 5'd24;

    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [MAX_LANES-1:0][LANE_W-1:0] lanes_t;
    typedef logic [2:0] lane_cnt_t;

    localparam lane_t PERM [PERM_D] = '{
        8'd103, 8'd152, 8'd181, 8'd5,   8'd117, 8'd148, 8'd142, 8'd43,
        8'd25,  8'd16,  8'd78,  8'd58,  8'd114, 8'd155, 8'd197, 8'd63,
        8'd76,  8'd241, 8'd160, 8'd74,  8'd59,  8'd199, 8'd2,   8'd62,
        8'd150, 8'd240, 8'd3,   8'd191, 8'd71,  8'd147, 8'd129, 8'd11,
        8'd70,  8'd7,   8'd51,  8'd221, 8'd109, 8'd50,  8'd201, 8'd118,
        8'd253, 8'd36,  8'd115, 8'd213, 8'd116, 8'd226, 8'd234, 8'd56,
        8'd91,  8'd79,  8'd28,  8'd177, 8'd95,  8'd124, 8'd94,  8'd157,
        8'd39,  8'd0,   8'd206, 8'd149, 8'd69,  8'd9,   8'd44,  8'd231,
        8'd8,   8'd52,  8'd242, 8'd106, 8'd153, 8'd202, 8'd88,  8'd37,
        8'd54,  8'd193, 8'd168, 8'd167, 8'd24,  8'd6,   8'd247, 8'd64,
        8'd175, 8'd189, 8'd166, 8'd111, 8'd19,  8'd169, 8'd209, 8'd204,
        8'd138, 8'd61,  8'd184, 8'd121, 8'd128, 8'd215, 8'd239, 8'd222,
        8'd162, 8'd196, 8'd174, 8'd237, 8'd127, 8'd136, 8'd154, 8'd212,
        8'd187, 8'd164, 8'd68,  8'd248, 8'd145, 8'd214, 8'd176, 8'd34,
        8'd245, 8'd80,  8'd188, 8'd137, 8'd35,  8'd251, 8'd194, 8'd66,
        8'd144, 8'd190, 8'd163, 8'd110, 8'd108, 8'd252, 8'd42,  8'd81,
        8'd133, 8'd233, 8'd85,  8'd99,  8'd130, 8'd244, 8'd57,  8'd97,
        8'd119, 8'd250, 8'd183, 8'd83,  8'd87,  8'd125, 8'd141, 8'd140,
        8'd113, 8'd210, 8'd82,  8'd22,  8'd200, 8'd223, 8'd26,  8'd18,
        8'd180, 8'd192, 8'd216, 8'd134, 8'd60,  8'd235, 8'd32,  8'd46,
        8'd219, 8'd41,  8'd77,  8'd143, 8'd86,  8'd96,  8'd72,  8'd151,
        8'd159, 8'd179, 8'd230, 8'd126, 8'd15,  8'd45,  8'd38,  8'd211,
        8'd243, 8'd229, 8'd10,  8'd207, 8'd208, 8'd132, 8'd255, 8'd104,
        8'd123, 8'd47,  8'd49,  8'd14,  8'd198, 8'd217, 8'd98,  8'd1,
        8'd203, 8'd105, 8'd135, 8'd205, 8'd21,  8'd139, 8'd156, 8'd20,
        8'd107, 8'd170, 8'd227, 8'd220, 8'd131, 8'd75,  8'd13,  8'd73,
        8'd89,  8'd249, 8'd48,  8'd158, 8'd30,  8'd40,  8'd225, 8'd93,
        8'd67,  8'd55,  8'd92,  8'd238, 8'd246, 8'd182, 8'd186, 8'd90,
        8'd236, 8'd65,  8'd172, 8'd101, 8'd171, 8'd112, 8'd4,   8'd195,
        8'd173, 8'd120, 8'd33,  8'd228, 8'd53,  8'd12,  8'd161, 8'd100,
        8'd102, 8'd218, 8'd23,  8'd29,  8'd254, 8'd232, 8'd31,  8'd224,
        8'd122, 8'd84,  8'd185, 8'd165, 8'd146, 8'd178, 8'd17,  8'd27
    };

    // lanes packed for a given bucket count, capped at MAX_LANES
    function automatic lane_cnt_t lanes_for_size(input logic [CFG_W-1:0] lg);
        lane_cnt_t n;
        if (lg <= LG_ONE_LANE)
            n = 3'd1;
        else if (lg <= LG_TWO_LANES)
            n = 3'd2;
        else if (lg <= LG_THREE_LANES)
            n = 3'd3;
        else
            n = 3'd4;
        if (n > lane_cnt_t'(MAX_LANES))
            n = lane_cnt_t'(MAX_LANES);
        return n;
    endfunction

    // low lane first, masked to bucket count minus one, cut to the hash width
    function automatic logic [HASH_W-1:0] pack_hash(input lanes_t lanes,
                                                    input logic [CFG_W-1:0] lg);
        logic [PACK_W-1:0] packed_val;
        logic [PACK_W-1:0] mask;
        lane_cnt_t         n;
        n          = lanes_for_size(lg);
        packed_val = '0;
        for (int j = 0; j < MAX_LANES; j++)
        begin
            if (j < int'(n))
                packed_val[j*LANE_W +: LANE_W] = lanes[j];
        end
        mask = (PACK_W'(1) << lg) - PACK_W'(1);
        return HASH_W'(packed_val & mask);
    endfunction

endpackage

`default_nettype wire

>>> hdl/pshash_if.sv
// channel interfaces of the string hash: byte stream, hash result, size register write
`default_nettype none

interface pshash_str_if;
    logic                            valid;
    logic                            ready;
    logic [pshash_pkg::BYTE_W-1:0]   char_byte;
    logic                            is_last;
    logic                            is_empty;

    modport source (output valid, output char_byte, output is_last, output is_empty,
                    input ready);
    modport sink   (input valid, input char_byte, input is_last, input is_empty,
                    output ready);
endinterface

interface pshash_hash_if;
    logic                            valid;
    logic                            ready;
    logic [pshash_pkg::HASH_W-1:0]   hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface pshash_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pshash_pkg::CFG_W-1:0]    table_size_log2;

    modport source (output valid, output table_size_log2, input ready);
    modport sink   (input valid, input table_size_log2, output ready);
endinterface

`default_nettype wire

>>> hdl/pshash_lane_update.sv
// per-lane permutation lookup for one string byte
`default_nettype none

module pshash_lane_update (
    input  wire logic [pshash_pkg::BYTE_W-1:0] char_byte,
    input  wire logic                          at_start,
    input  wire pshash_pkg::lanes_t            lanes_cur,
    output pshash_pkg::lanes_t                 lanes_next
);

    pshash_pkg::lane_t idx [pshash_pkg::MAX_LANES];

    for (genvar j = 0; j < pshash_pkg::MAX_LANES; j++)
    begin : g_lane
        // first byte seeds each lane with its own offset
        assign idx[j] = at_start ? pshash_pkg::lane_t'(char_byte + pshash_pkg::BYTE_W'(j))
                                 : (lanes_cur[j] ^ char_byte);
        assign lanes_next[j] = pshash_pkg::PERM[idx[j]];
    end

endmodule

`default_nettype wire

>>> hdl/pearson_string_hash.sv
// top level of the multi-lane pearson string hash
`default_nettype none

// pearson string hash: a string comes in one byte per transaction on str, with
// is_last on its final byte, or as a single transaction with is_empty set for
// an empty string. one bucket index leaves on hash for every last or empty
// transaction, none for middle bytes. up to four 8-bit lanes walk a fixed
// 256-entry permutation table; the lanes are packed low lane first and masked
// to 2^table_size_log2 - 1, with the lane count following from that size
// (up to 8 bits one lane, up to 16 two, up to 24 three, else four). the size
// register is written on cfg (reset 4) and is read when the last byte is
// processed, so write it between strings. rate: one byte per clock while no
// result is stalled; a result is registered in the input stage and from there
// in the output register that drives hash. the rate is set by the lane loop:
// each byte's lookup needs the lane values of the byte before, and that lookup
// sits between the input stage and the lane registers. str is stalled only while
// a result waits in the stage and the output register holds one not yet taken.

module pearson_string_hash (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pshash_str_if.sink         str,
    pshash_hash_if.source      hash,
    pshash_cfg_if.sink         cfg
);

    // input stage
    logic                              stage_valid_reg, stage_valid_next;
    logic [pshash_pkg::BYTE_W-1:0]     stage_byte_reg;
    logic                              stage_last_reg;
    logic                              stage_empty_reg;

    // hash state
    pshash_pkg::lanes_t                lanes_reg, lanes_next;
    logic                              at_start_reg, at_start_next;
    logic [pshash_pkg::CFG_W-1:0]      size_reg, size_next;

    // output register
    logic                              out_valid_reg, out_valid_next;
    logic [pshash_pkg::HASH_W-1:0]     out_hash_reg, out_hash_next;

    pshash_pkg::lanes_t                lanes_upd;
    logic                              str_accept;
    logic                              stage_result;
    logic                              out_free;
    logic                              stage_advance;

    pshash_lane_update u_lanes (
        .char_byte  (stage_byte_reg),
        .at_start   (at_start_reg),
        .lanes_cur  (lanes_reg),
        .lanes_next (lanes_upd)
    );

    // handshake: the stage moves on unless its result finds the output full
    assign stage_result  = stage_empty_reg | stage_last_reg;
    assign out_free      = ~out_valid_reg | hash.ready;
    assign stage_advance = stage_valid_reg & (~stage_result | out_free);
    assign str.ready     = ~stage_valid_reg | stage_advance;
    assign str_accept    = str.valid & str.ready;
    assign cfg.ready     = 1'b1;

    assign hash.valid      = out_valid_reg;
    assign hash.hash_value = out_hash_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        lanes_next       = lanes_reg;
        at_start_next    = at_start_reg;
        size_next        = size_reg;
        out_valid_next   = out_valid_reg;
        out_hash_next    = out_hash_reg;

        if (str_accept)
            stage_valid_next = 1'b1;
        else if (stage_advance)
            stage_valid_next = 1'b0;

        if (cfg.valid)
            size_next = cfg.table_size_log2;

        // output drains when taken, refills from a finishing string
        if (hash.ready)
            out_valid_next = 1'b0;

        if (stage_advance)
        begin
            if (stage_empty_reg)
            begin
                // empty string: lanes kept, zero result
                at_start_next  = 1'b1;
                out_valid_next = 1'b1;
                out_hash_next  = '0;
            end
            else
            begin
                lanes_next    = lanes_upd;
                at_start_next = stage_last_reg;
                if (stage_last_reg)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = pshash_pkg::pack_hash(lanes_upd, size_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            lanes_reg       <= '0;
            at_start_reg    <= 1'b1;
            size_reg        <= pshash_pkg::CFG_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            lanes_reg       <= lanes_next;
            at_start_reg    <= at_start_next;
            size_reg        <= size_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (str_accept)
        begin
            stage_byte_reg  <= str.char_byte;
            stage_last_reg  <= str.is_last;
            stage_empty_reg <= str.is_empty;
        end
        out_hash_reg <= out_hash_next;
    end

endmodule

`default_nettype wire

>>> hdl/pshash_checker.sv
// port-level checker of the string hash and its bind to the top level
`default_nettype none

`include "pearson_string_hash_assert.svh"

module pshash_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          str_valid,
    input  wire logic                          str_ready,
    input  wire logic                          str_is_last,
    input  wire logic                          str_is_empty,
    input  wire logic                          hash_valid,
    input  wire logic                          hash_ready,
    input  wire logic [pshash_pkg::HASH_W-1:0] hash_value
);

    // a waiting result holds its value
    `PSH_ASSERT_NEXT(a_hash_hold, hash_valid && !hash_ready, hash_valid && $stable(hash_value), "hash result dropped or changed while stalled")

    // a fresh result comes from a last or empty byte taken earlier
    `PSH_ASSERT_NOW(a_result_source, $rose(hash_valid), $past(str_valid && str_ready && (str_is_last || str_is_empty), 2), "hash result without a finishing transaction")

    // the byte stream stalls only behind a stalled result
    `PSH_ASSERT_NOW(a_stall_cause, !str_ready, hash_valid && !hash_ready, "byte stream stalled with the output free")

endmodule

bind pearson_string_hash pshash_checker u_pshash_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .str_valid    (str.valid),
    .str_ready    (str.ready),
    .str_is_last  (str.is_last),
    .str_is_empty (str.is_empty),
    .hash_valid   (hash.valid),
    .hash_ready   (hash.ready),
    .hash_value   (hash.hash_value)
);

`default_nettype wire
